// ----- hw/rtl/uls_pkg.sv -----
package uls_pkg;

	localparam int COLUMN_BITS_DEF = 16;
	localparam int LINE_BITS_DEF   = 32;

	// Fixed widths of the result fields.
	localparam int CP_W     = 31;
	localparam int LINE_W   = 32;
	localparam int COLUMN_W = 16;

	// Result queue.
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_LINE_END = 2'd1,
		KIND_END      = 2'd2,
		KIND_INVALID  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		kind_t                kind;
		logic [CP_W-1:0]      code_point;
		logic [LINE_W-1:0]    line_number;
		logic [COLUMN_W-1:0]  column;
		logic                 last;
	} out_item_t;

	// Results produced by one input stage cycle: 0, 1 or 2 entries.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  item0;
		out_item_t  item1;
	} push_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] free;
	} fifo_stat_t;

endpackage

// ----- hw/rtl/uls_stream_if.sv -----
interface uls_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/uls_decode.sv -----
module uls_decode import uls_pkg::*; #(
	parameter int COLUMN_BITS = COLUMN_BITS_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	uls_stream_if.sink   text,
	input  fifo_stat_t   stat,
	output push_t        push
);

	logic                   valid_s1;
	in_item_t               item_s1;

	logic [CP_W-1:0]        acc_q, acc_d;
	logic [2:0]             rem_q, rem_d;
	logic                   inv_q, inv_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] chars_q, chars_d;

	logic [7:0]             b;
	logic [CP_W-1:0]        acc_shift;
	logic [CP_W-1:0]        fin_cp;
	logic                   fin_en;
	logic [LINE_BITS-1:0]   line_inc;

	function automatic out_item_t make_item(kind_t k, logic [CP_W-1:0] cp,
		logic [LINE_BITS-1:0] ln, logic [COLUMN_BITS-1:0] col, logic lst);
		out_item_t r;
		r.kind        = k;
		r.code_point  = cp;
		r.line_number = LINE_W'(ln);
		r.column      = COLUMN_W'(col);
		r.last        = lst;
		return r;
	endfunction

	// Room for what the input stage may push now plus what a new request may push next.
	assign text.ready = valid_s1 ? (stat.free >= FIFO_CNT_W'(4))
	                             : (stat.free >= FIFO_CNT_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text.valid && text.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1 <= text.payload;
		end
	end

	assign b         = item_s1.data_byte;
	assign acc_shift = {acc_q[CP_W-7:0], b[5:0]};
	assign line_inc  = line_q + LINE_BITS'(1);

	always_comb begin
		acc_d      = acc_q;
		rem_d      = rem_q;
		inv_d      = inv_q;
		line_d     = line_q;
		chars_d    = chars_q;
		fin_cp     = '0;
		fin_en     = 1'b0;
		push.count = 2'd0;
		push.item0 = make_item(KIND_END, '0, line_q, '0, 1'b1);
		push.item1 = make_item(KIND_END, '0, line_inc, '0, 1'b1);

		if (valid_s1) begin
			if (item_s1.end_of_input) begin
				acc_d = '0;
				rem_d = '0;
				inv_d = 1'b0;
				if (chars_q != '0) begin
					push.count = 2'd2;
					push.item0 = make_item(KIND_LINE_END, '0, line_q, chars_q, 1'b0);
					line_d     = line_inc;
					chars_d    = '0;
				end else begin
					push.count = 2'd1;
				end
			end else if (rem_q != 3'd0) begin
				acc_d = acc_shift;
				rem_d = rem_q - 3'd1;
				if (rem_q == 3'd1) begin
					if (inv_q) begin
						inv_d      = 1'b0;
						push.count = 2'd1;
						push.item0 = make_item(KIND_INVALID, '0, line_q, chars_q, 1'b1);
						line_d     = line_inc;
						chars_d    = '0;
					end else begin
						fin_en = 1'b1;
						fin_cp = acc_shift;
					end
				end
			end else if (b < ASCII_LIMIT) begin
				fin_en = 1'b1;
				fin_cp = CP_W'(b);
			end else begin
				inv_d = 1'b0;
				case (b) inside
					8'b110?????: begin
						acc_d = CP_W'(b[4:0]);
						rem_d = 3'd1;
					end
					8'b1110????: begin
						acc_d = CP_W'(b[3:0]);
						rem_d = 3'd2;
					end
					8'b11110???: begin
						acc_d = CP_W'(b[2:0]);
						rem_d = 3'd3;
					end
					8'b111110??: begin
						acc_d = CP_W'(b[1:0]);
						rem_d = 3'd4;
					end
					8'b1111110?: begin
						acc_d = CP_W'(b[0]);
						rem_d = 3'd5;
					end
					default: begin
						// stray continuation byte or 0xFE/0xFF
						acc_d = '0;
						rem_d = 3'd5;
						inv_d = 1'b1;
					end
				endcase
			end

			if (fin_en) begin
				if (fin_cp == CP_W'(CHAR_CR)) begin
					push.count = 2'd0;
				end else if (fin_cp == CP_W'(CHAR_LF)) begin
					push.count = 2'd1;
					push.item0 = make_item(KIND_LINE_END, '0, line_q, chars_q, 1'b1);
					line_d     = line_inc;
					chars_d    = '0;
				end else begin
					if (chars_q != '1) begin
						chars_d = chars_q + COLUMN_BITS'(1);
					end
					push.count = 2'd1;
					push.item0 = make_item(KIND_CHAR, fin_cp, line_q, chars_d, 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			rem_q   <= '0;
			inv_q   <= 1'b0;
			line_q  <= LINE_BITS'(1);
			chars_q <= '0;
		end else begin
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			inv_q   <= inv_d;
			line_q  <= line_d;
			chars_q <= chars_d;
		end
	end

	chk_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (FIFO_CNT_W'(push.count) <= stat.free))
		else $error("result pushed without room in queue");

	chk_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd5)
		else $error("continuation count out of range");

	chk_inv_needs_rem: assert property (@(posedge clk) disable iff (!arst_n)
		inv_q |-> (rem_q != 3'd0))
		else $error("invalid sequence flag set with no bytes pending");

endmodule

// ----- hw/rtl/uls_result_fifo.sv -----
module uls_result_fifo import uls_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	output fifo_stat_t   stat,
	uls_stream_if.source result
);

	out_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [FIFO_PTR_W-1:0] wr_ptr_nxt;
	logic                  pop;

	assign wr_ptr_nxt     = wr_ptr_q + FIFO_PTR_W'(1);
	assign pop            = result.valid && result.ready;
	assign result.valid   = (count_q != '0);
	assign result.payload = mem_q[rd_ptr_q];
	assign stat.free      = FIFO_CNT_W'(FIFO_DEPTH) - count_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nxt] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
		end
	end

	chk_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue count above depth");

	chk_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two results in one cycle");

	chk_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (!push.item0.last && push.item1.last))
		else $error("last flag misplaced in result pair");

endmodule

// ----- hw/rtl/utf8_line_scanner_core.sv -----
// UTF-8 line scanner: takes one byte request per cycle while text.ready is high (or an end
// flag) and emits code points tagged with line number and saturating column, line-end,
// invalid-sequence and end-of-input markers. A byte is registered on acceptance and decoded
// the next cycle; its result lands in an 8-entry result queue, from which it is offered on
// result. Sustained rate is one byte per clock while the queue has room; an end flag on a
// non-empty line yields two results, drained one per cycle from the queue while result.ready
// is high. text.ready drops only when the queue lacks room for two results beyond those the
// decode stage may still push.
module utf8_line_scanner_core import uls_pkg::*; #(
	parameter int COLUMN_BITS = COLUMN_BITS_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	uls_stream_if.sink   text,
	uls_stream_if.source result
);

	push_t      push;
	fifo_stat_t stat;

	uls_decode #(
		.COLUMN_BITS(COLUMN_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.stat   (stat),
		.push   (push)
	);

	uls_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.stat   (stat),
		.result (result)
	);

endmodule
